// ----- hdl/bur_pkg.sv -----
// shared constants and types for the baseline uvw rotation block
package bur_pkg;

    localparam int LEN_W    = 40;
    localparam int TRIG_W   = 32;
    localparam int WL_W     = 32;
    localparam int WAVES_W  = 48;
    localparam int COEF_W   = 34;
    localparam int ACC_W    = 80;
    localparam int RND_W    = 50;
    localparam int DIVD_W   = 64;
    localparam int FRAC_SH  = 30;
    localparam int WL_SH    = 24;

    // register stages ahead of the divider lanes
    localparam int FRONT_STAGES = 7;
    // divider lane: dividend stage, one stage per quotient bit, output stage
    localparam int DIV_STAGES   = DIVD_W + 2;
    localparam int LATENCY      = FRONT_STAGES + DIV_STAGES;

    localparam int NUM_LANES = 3;
    localparam int NUM_TERMS = 3;

    typedef enum logic [0:0] {
        REG_SIN_DEC = 1'b0,
        REG_COS_DEC = 1'b1
    } cfg_index_t;

    localparam logic signed [TRIG_W-1:0] COS_DEC_RESET = 32'sd1073741824;

endpackage

// ----- hdl/baseline_uvw_rotation.sv -----
// top level: baseline xyz to uvw rotation with division by wavelength
//
// Input channel: in_valid / in_stall carry one baseline word (x, y, z
// offsets, hour angle sine and cosine, wavelength). Output channel:
// out_valid / out_stall carry the u, v, w word in metres and wavelengths.
// A word moves when valid is high and stall is low.
// Configuration: cfg_we writes cfg_data to the register picked by
// cfg_index (0: declination sine, 1: declination cosine); write only
// while no word is in flight.
// Input acceptance to output valid: 7 stages of rotation (input capture,
// coefficient products, rounding, split 32-bit partial products, term
// assembly, sum and round, saturation), then 66 stages in each of the
// three divider lanes (dividend stage, one per quotient bit, output stage).
// Throughput is one word per cycle while the receiver does not stall.
// Reset clears all valid bits and loads declination sine 0, cosine 1.0.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and in_stall rises; nothing is dropped or repeated.
module baseline_uvw_rotation
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [bur_pkg::LEN_W-1:0]    x_diff,
    input  logic signed [bur_pkg::LEN_W-1:0]    y_diff,
    input  logic signed [bur_pkg::LEN_W-1:0]    z_diff,
    input  logic signed [bur_pkg::TRIG_W-1:0]   sin_hour_angle,
    input  logic signed [bur_pkg::TRIG_W-1:0]   cos_hour_angle,
    input  logic        [bur_pkg::WL_W-1:0]     wavelength,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [bur_pkg::LEN_W-1:0]    u_metres,
    output logic signed [bur_pkg::LEN_W-1:0]    v_metres,
    output logic signed [bur_pkg::LEN_W-1:0]    w_metres,
    output logic signed [bur_pkg::WAVES_W-1:0]  u_waves,
    output logic signed [bur_pkg::WAVES_W-1:0]  v_waves,
    output logic signed [bur_pkg::WAVES_W-1:0]  w_waves,
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_index,
    input  logic [bur_pkg::TRIG_W-1:0]          cfg_data
);

    localparam int LAT = bur_pkg::LATENCY;
    localparam int NL  = bur_pkg::NUM_LANES;
    localparam int NT  = bur_pkg::NUM_TERMS;
    localparam int LW  = bur_pkg::LEN_W;
    localparam int TW  = bur_pkg::TRIG_W;
    localparam int CW  = bur_pkg::COEF_W;
    localparam int AW  = bur_pkg::ACC_W;
    localparam int RW  = bur_pkg::RND_W;
    localparam int PLW = CW + 33;
    localparam int PHW = CW + 8;

    logic signed [TW-1:0] sin_dec_reg;
    logic signed [TW-1:0] cos_dec_reg;
    logic                 vld_reg [0:LAT-1];
    logic                 en;

    // stage 1: input capture
    logic signed [LW-1:0]          x1_reg, y1_reg, z1_reg;
    logic signed [TW-1:0]          sh1_reg, ch1_reg;
    logic [bur_pkg::WL_W-1:0]      wl1_reg;
    // stage 2: trig products
    logic signed [2*TW-1:0]        psc_reg, pss_reg, pcc_reg, pcs_reg;
    logic signed [LW-1:0]          v2_reg [0:NT-1];
    logic signed [TW-1:0]          sh2_reg, ch2_reg;
    logic [bur_pkg::WL_W-1:0]      wl2_reg;
    // stage 3: rounded coefficients
    logic signed [CW-1:0]          c3_reg [0:NL-1][0:NT-1];
    logic signed [LW-1:0]          v3_reg [0:NT-1];
    logic [bur_pkg::WL_W-1:0]      wl3_reg;
    // stage 4: split partial products
    logic signed [PLW-1:0]         plo4_reg [0:NL-1][0:NT-1];
    logic signed [PHW-1:0]         phi4_reg [0:NL-1][0:NT-1];
    logic [bur_pkg::WL_W-1:0]      wl4_reg;
    // stage 5: full terms
    logic signed [AW-1:0]          t5_reg [0:NL-1][0:NT-1];
    logic [bur_pkg::WL_W-1:0]      wl5_reg;
    // stage 6: rounded sums
    logic signed [RW-1:0]          r6_reg [0:NL-1];
    logic [bur_pkg::WL_W-1:0]      wl6_reg;
    // stage 7: saturated metres
    logic signed [LW-1:0]          m7_reg [0:NL-1];
    logic [bur_pkg::WL_W-1:0]      wl7_reg;

    logic signed [CW-1:0]          ksc, kss, kcc, kcs;
    logic signed [RW-1:0]          r_next [0:NL-1];
    logic signed [LW-1:0]          m_next [0:NL-1];

    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_dec_reg <= '0;
            cos_dec_reg <= bur_pkg::COS_DEC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (bur_pkg::cfg_index_t'(cfg_index))
                bur_pkg::REG_SIN_DEC: sin_dec_reg <= signed'(cfg_data);
                bur_pkg::REG_COS_DEC: cos_dec_reg <= signed'(cfg_data);
                default:              sin_dec_reg <= sin_dec_reg;
            endcase
        end
    end

    // valid bits travel with the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // coefficient rounding to q3.30
    always_comb
    begin
        ksc = CW'((psc_reg + (64'sd1 <<< (bur_pkg::FRAC_SH-1))) >>> bur_pkg::FRAC_SH);
        kss = CW'((pss_reg + (64'sd1 <<< (bur_pkg::FRAC_SH-1))) >>> bur_pkg::FRAC_SH);
        kcc = CW'((pcc_reg + (64'sd1 <<< (bur_pkg::FRAC_SH-1))) >>> bur_pkg::FRAC_SH);
        kcs = CW'((pcs_reg + (64'sd1 <<< (bur_pkg::FRAC_SH-1))) >>> bur_pkg::FRAC_SH);
    end

    // sum, round and saturate per lane
    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            r_next[l] = RW'((t5_reg[l][0] + t5_reg[l][1] + t5_reg[l][2]
                            + (80'sd1 <<< (bur_pkg::FRAC_SH-1))) >>> bur_pkg::FRAC_SH);
            if (r6_reg[l] > RW'(signed'({1'b0, {(LW-1){1'b1}}})))
                m_next[l] = {1'b0, {(LW-1){1'b1}}};
            else if (r6_reg[l] < RW'(signed'({1'b1, {(LW-1){1'b0}}})))
                m_next[l] = {1'b1, {(LW-1){1'b0}}};
            else
                m_next[l] = r6_reg[l][LW-1:0];
        end
    end

    // rotation pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= x_diff;
            y1_reg  <= y_diff;
            z1_reg  <= z_diff;
            sh1_reg <= sin_hour_angle;
            ch1_reg <= cos_hour_angle;
            wl1_reg <= wavelength;

            psc_reg    <= sin_dec_reg * ch1_reg;
            pss_reg    <= sin_dec_reg * sh1_reg;
            pcc_reg    <= cos_dec_reg * ch1_reg;
            pcs_reg    <= cos_dec_reg * sh1_reg;
            v2_reg[0]  <= x1_reg;
            v2_reg[1]  <= y1_reg;
            v2_reg[2]  <= z1_reg;
            sh2_reg    <= sh1_reg;
            ch2_reg    <= ch1_reg;
            wl2_reg    <= wl1_reg;

            c3_reg[0][0] <= CW'(sh2_reg);
            c3_reg[0][1] <= CW'(ch2_reg);
            c3_reg[0][2] <= '0;
            c3_reg[1][0] <= -ksc;
            c3_reg[1][1] <= kss;
            c3_reg[1][2] <= CW'(cos_dec_reg);
            c3_reg[2][0] <= kcc;
            c3_reg[2][1] <= -kcs;
            c3_reg[2][2] <= CW'(sin_dec_reg);
            for (int t = 0; t < NT; t++)
                v3_reg[t] <= v2_reg[t];
            wl3_reg <= wl2_reg;

            for (int l = 0; l < NL; l++)
                for (int t = 0; t < NT; t++)
                begin
                    plo4_reg[l][t] <= c3_reg[l][t] * $signed({1'b0, v3_reg[t][31:0]});
                    phi4_reg[l][t] <= c3_reg[l][t] * $signed(v3_reg[t][LW-1:32]);
                end
            wl4_reg <= wl3_reg;

            for (int l = 0; l < NL; l++)
                for (int t = 0; t < NT; t++)
                    t5_reg[l][t] <= AW'(signed'({phi4_reg[l][t], 32'd0}))
                                  + AW'(plo4_reg[l][t]);
            wl5_reg <= wl4_reg;

            for (int l = 0; l < NL; l++)
                r6_reg[l] <= r_next[l];
            wl6_reg <= wl5_reg;

            for (int l = 0; l < NL; l++)
                m7_reg[l] <= m_next[l];
            wl7_reg <= wl6_reg;
        end
    end

    // divider lanes
    bur_div u_div_u
    (
        .clk        (clk),
        .en         (en),
        .metres     (m7_reg[0]),
        .wavelength (wl7_reg),
        .metres_out (u_metres),
        .waves_out  (u_waves)
    );

    bur_div u_div_v
    (
        .clk        (clk),
        .en         (en),
        .metres     (m7_reg[1]),
        .wavelength (wl7_reg),
        .metres_out (v_metres),
        .waves_out  (v_waves)
    );

    bur_div u_div_w
    (
        .clk        (clk),
        .en         (en),
        .metres     (m7_reg[2]),
        .wavelength (wl7_reg),
        .metres_out (w_metres),
        .waves_out  (w_waves)
    );

    assign out_valid = vld_reg[LAT-1];

endmodule

// ----- hdl/bur_div.sv -----
// pipelined divider lane: metres to wavelengths with rounding and saturation
module bur_div
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [bur_pkg::LEN_W-1:0]    metres,
    input  logic        [bur_pkg::WL_W-1:0]     wavelength,
    output logic signed [bur_pkg::LEN_W-1:0]    metres_out,
    output logic signed [bur_pkg::WAVES_W-1:0]  waves_out
);

    localparam int N = bur_pkg::DIVD_W;

    logic [N-1:0]                      num_reg [0:N];
    logic [bur_pkg::WL_W-1:0]          rem_reg [0:N];
    logic [bur_pkg::WL_W-1:0]          wl_reg  [0:N];
    logic                              neg_reg [0:N];
    logic                              zero_reg[0:N];
    logic signed [bur_pkg::LEN_W-1:0]  m_reg   [0:N];
    logic signed [bur_pkg::LEN_W-1:0]  metres_out_reg;
    logic signed [bur_pkg::WAVES_W-1:0] waves_out_reg;

    logic [bur_pkg::LEN_W-1:0]         mag;
    logic [N-1:0]                      dividend;
    logic [N-1:0]                      quo;
    logic [bur_pkg::WAVES_W-1:0]       waves_next;

    // magnitude, scaled dividend with half-divisor rounding term
    always_comb
    begin
        mag      = metres[bur_pkg::LEN_W-1] ? (bur_pkg::LEN_W)'(-metres)
                                            : (bur_pkg::LEN_W)'(metres);
        dividend = {mag, {bur_pkg::WL_SH{1'b0}}}
                 + {{(N-bur_pkg::WL_W+1){1'b0}}, wavelength[bur_pkg::WL_W-1:1]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0]  <= dividend;
            rem_reg[0]  <= '0;
            wl_reg[0]   <= wavelength;
            neg_reg[0]  <= metres[bur_pkg::LEN_W-1];
            zero_reg[0] <= (metres == '0);
            m_reg[0]    <= metres;
        end
    end

    // one quotient bit per stage, restoring form
    genvar gi;
    generate
        for (gi = 1; gi <= N; gi++)
        begin : g_step
            logic [bur_pkg::WL_W:0] trial;
            logic                   ge;
            always_comb
            begin
                trial = {rem_reg[gi-1], num_reg[gi-1][N-1]};
                ge    = (trial >= {1'b0, wl_reg[gi-1]});
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[gi]  <= ge ? bur_pkg::WL_W'(trial - {1'b0, wl_reg[gi-1]})
                                       : trial[bur_pkg::WL_W-1:0];
                    num_reg[gi]  <= {num_reg[gi-1][N-2:0], ge};
                    wl_reg[gi]   <= wl_reg[gi-1];
                    neg_reg[gi]  <= neg_reg[gi-1];
                    zero_reg[gi] <= zero_reg[gi-1];
                    m_reg[gi]    <= m_reg[gi-1];
                end
            end
        end
    endgenerate

    // sign and saturation of the quotient
    always_comb
    begin
        quo = num_reg[N];
        if (zero_reg[N])
            waves_next = '0;
        else if (neg_reg[N])
        begin
            if (quo >= {{(N-bur_pkg::WAVES_W){1'b0}}, 1'b1, {(bur_pkg::WAVES_W-1){1'b0}}})
                waves_next = {1'b1, {(bur_pkg::WAVES_W-1){1'b0}}};
            else
                waves_next = bur_pkg::WAVES_W'(0) - quo[bur_pkg::WAVES_W-1:0];
        end
        else
        begin
            if (quo > {{(N-bur_pkg::WAVES_W+1){1'b0}}, {(bur_pkg::WAVES_W-1){1'b1}}})
                waves_next = {1'b0, {(bur_pkg::WAVES_W-1){1'b1}}};
            else
                waves_next = quo[bur_pkg::WAVES_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            metres_out_reg <= m_reg[N];
            waves_out_reg  <= signed'(waves_next);
        end
    end

    assign metres_out = metres_out_reg;
    assign waves_out  = waves_out_reg;

endmodule

// ----- tb/testbench.sv -----
// testbench for the baseline xyz to uvw rotation block
`timescale 1ns / 1ps

typedef struct {
    logic signed [bur_pkg::LEN_W-1:0]   um, vm, wm;
    logic signed [bur_pkg::WAVES_W-1:0] uw, vw, ww;
} uvw_word_t;

// scoreboard: predicts the uvw word for each accepted baseline and checks results
class uvw_scoreboard;
    logic signed [bur_pkg::TRIG_W-1:0] sin_dec;
    logic signed [bur_pkg::TRIG_W-1:0] cos_dec;
    uvw_word_t pending[$];
    int errors;
    int checked;

    function new();
        sin_dec = 0;
        cos_dec = bur_pkg::COS_DEC_RESET;
        errors = 0;
        checked = 0;
    endfunction

    // q1.30 product rounded half up, floor shift
    function automatic logic signed [63:0] trig_prod(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b + (64'sd1 <<< 29);
        return p >>> 30;
    endfunction

    // round q.46 sum to q.16 and clamp to 40 bits
    function automatic logic signed [bur_pkg::LEN_W-1:0] round_clamp(
            logic signed [127:0] acc);
        logic signed [127:0] r;
        r = (acc + (128'sd1 <<< 29)) >>> 30;
        if (r > 128'sd549755813887)
            return {1'b0, {(bur_pkg::LEN_W-1){1'b1}}};
        if (r < -128'sd549755813888)
            return {1'b1, {(bur_pkg::LEN_W-1){1'b0}}};
        return r[bur_pkg::LEN_W-1:0];
    endfunction

    // metres to wavelengths, round half away from zero, clamp to 48 bits
    function automatic logic signed [bur_pkg::WAVES_W-1:0] in_waves(
            logic signed [bur_pkg::LEN_W-1:0] m, logic [bur_pkg::WL_W-1:0] wl);
        logic [127:0] mag;
        logic [127:0] q;
        mag = m < 0 ? 128'(-64'(m)) : 128'(m);
        if (mag == 0)
            return '0;
        if (wl == 0)
            q = {128{1'b1}};
        else
            q = ((mag << bur_pkg::WL_SH) + (wl >> 1)) / wl;
        if (m < 0)
        begin
            if (q > (128'd1 << 47))
                q = 128'd1 << 47;
            return -q[bur_pkg::WAVES_W-1:0];
        end
        if (q > (128'd1 << 47) - 1)
            q = (128'd1 << 47) - 1;
        return q[bur_pkg::WAVES_W-1:0];
    endfunction

    function void write_reg(bur_pkg::cfg_index_t idx, logic [bur_pkg::TRIG_W-1:0] val);
        if (idx == bur_pkg::REG_SIN_DEC)
            sin_dec = val;
        else
            cos_dec = val;
    endfunction

    function void note_baseline(logic signed [bur_pkg::LEN_W-1:0] x,
                                logic signed [bur_pkg::LEN_W-1:0] y,
                                logic signed [bur_pkg::LEN_W-1:0] z,
                                logic signed [bur_pkg::TRIG_W-1:0] sh,
                                logic signed [bur_pkg::TRIG_W-1:0] ch,
                                logic [bur_pkg::WL_W-1:0] wl);
        logic signed [127:0] xx, yy, zz, sd, cd, k_sc, k_ss, k_cc, k_cs;
        uvw_word_t e;
        xx = x;
        yy = y;
        zz = z;
        sd = sin_dec;
        cd = cos_dec;
        k_sc = trig_prod(sin_dec, ch);
        k_ss = trig_prod(sin_dec, sh);
        k_cc = trig_prod(cos_dec, ch);
        k_cs = trig_prod(cos_dec, sh);
        e.um = round_clamp(128'(sh) * xx + 128'(ch) * yy);
        e.vm = round_clamp(-k_sc * xx + k_ss * yy + cd * zz);
        e.wm = round_clamp(k_cc * xx - k_cs * yy + sd * zz);
        e.uw = in_waves(e.um, wl);
        e.vw = in_waves(e.vm, wl);
        e.ww = in_waves(e.wm, wl);
        pending.push_back(e);
    endfunction

    function void check_word(uvw_word_t a);
        uvw_word_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected uvw word u=%0d v=%0d w=%0d", $time, a.um, a.vm, a.wm);
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (a.um !== e.um)
        begin
            $display("%0t: u_metres expected %0d actual %0d", $time, e.um, a.um);
            errors++;
        end
        if (a.vm !== e.vm)
        begin
            $display("%0t: v_metres expected %0d actual %0d", $time, e.vm, a.vm);
            errors++;
        end
        if (a.wm !== e.wm)
        begin
            $display("%0t: w_metres expected %0d actual %0d", $time, e.wm, a.wm);
            errors++;
        end
        if (a.uw !== e.uw)
        begin
            $display("%0t: u_waves expected %0d actual %0d", $time, e.uw, a.uw);
            errors++;
        end
        if (a.vw !== e.vw)
        begin
            $display("%0t: v_waves expected %0d actual %0d", $time, e.vw, a.vw);
            errors++;
        end
        if (a.ww !== e.ww)
        begin
            $display("%0t: w_waves expected %0d actual %0d", $time, e.ww, a.ww);
            errors++;
        end
    endfunction
endclass

module testbench;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [bur_pkg::LEN_W-1:0] x_diff = '0, y_diff = '0, z_diff = '0;
    logic signed [bur_pkg::TRIG_W-1:0] sin_hour_angle = '0, cos_hour_angle = '0;
    logic [bur_pkg::WL_W-1:0] wavelength = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [bur_pkg::LEN_W-1:0] u_metres, v_metres, w_metres;
    logic signed [bur_pkg::WAVES_W-1:0] u_waves, v_waves, w_waves;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = '0;
    logic [bur_pkg::TRIG_W-1:0] cfg_data = '0;

    uvw_scoreboard board = new();
    bit quiet = 1'b0;
    int baselines = 0;

    localparam logic signed [bur_pkg::LEN_W-1:0] LEN_MAX = {1'b0, {(bur_pkg::LEN_W-1){1'b1}}};
    localparam logic signed [bur_pkg::LEN_W-1:0] LEN_MIN = {1'b1, {(bur_pkg::LEN_W-1){1'b0}}};
    localparam logic signed [bur_pkg::TRIG_W-1:0] ONE_Q30 = 32'sd1073741824;

    baseline_uvw_rotation u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver: random stall bursts, checks each accepted word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word('{u_metres, v_metres, w_metres, u_waves, v_waves, w_waves});
    end

    initial
    begin
        int gap;
        gap = 0;
        forever
        begin
            @(posedge clk);
            if (gap > 0)
                gap--;
            else if (!quiet && $urandom_range(0, 9) == 0)
                gap = $urandom_range(1, 5);
            out_stall <= (gap > 0);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random offset: half modest lengths, else full-width random or an extreme
    function automatic logic signed [bur_pkg::LEN_W-1:0] rand_len();
        case ($urandom_range(0, 3))
            0: return bur_pkg::LEN_W'(rand64());
            1: return $urandom_range(0, 1) ? LEN_MAX : LEN_MIN;
            default: return 40'(signed'($urandom) >>> $urandom_range(0, 8)) <<<
                            $urandom_range(0, 8);
        endcase
    endfunction

    function automatic logic signed [bur_pkg::TRIG_W-1:0] rand_trig();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? ONE_Q30 : -ONE_Q30;
            default: return $urandom_range(0, 2 * ONE_Q30) - ONE_Q30;
        endcase
    endfunction

    function automatic logic [bur_pkg::WL_W-1:0] rand_wl();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3);
            1: return $urandom;
            default: return $urandom_range(1 << 20, 1 << 28);
        endcase
    endfunction

    // drive one baseline word and wait for acceptance; valid stays up
    // between back-to-back words and drops only for an idle burst or a drain
    task automatic send_baseline(logic signed [bur_pkg::LEN_W-1:0] x,
                                 logic signed [bur_pkg::LEN_W-1:0] y,
                                 logic signed [bur_pkg::LEN_W-1:0] z,
                                 logic signed [bur_pkg::TRIG_W-1:0] sh,
                                 logic signed [bur_pkg::TRIG_W-1:0] ch,
                                 logic [bur_pkg::WL_W-1:0] wl);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_diff <= x;
        y_diff <= y;
        z_diff <= z;
        sin_hour_angle <= sh;
        cos_hour_angle <= ch;
        wavelength <= wl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_baseline(x, y, z, sh, ch, wl);
        baselines++;
    endtask

    task automatic send_random();
        send_baseline(rand_len(), rand_len(), rand_len(), rand_trig(), rand_trig(),
                      rand_wl());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (bur_pkg::LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(bur_pkg::cfg_index_t idx, logic [bur_pkg::TRIG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, val);
        @(posedge clk);
    endtask

    initial
    begin
        logic [bur_pkg::TRIG_W-1:0] sd_set[5];
        logic [bur_pkg::TRIG_W-1:0] cd_set[5];
        sd_set = '{32'd0, ONE_Q30, -ONE_Q30, 32'h8000_0000, 32'd759250125};
        cd_set = '{ONE_Q30, 32'd0, -ONE_Q30, 32'h7fff_ffff, 32'd759250125};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero and tiny wavelengths, sign ties at reset setting
        send_baseline(0, 0, 0, 0, ONE_Q30, 0);
        send_baseline(LEN_MAX, LEN_MAX, LEN_MAX, ONE_Q30, ONE_Q30, 0);
        send_baseline(LEN_MIN, LEN_MIN, LEN_MIN, ONE_Q30, ONE_Q30, 0);
        send_baseline(LEN_MIN, LEN_MAX, LEN_MIN, -ONE_Q30, ONE_Q30, 1);
        send_baseline(LEN_MAX, LEN_MIN, LEN_MAX, 32'h7fff_ffff, 32'h8000_0000, 1);
        send_baseline(LEN_MIN, LEN_MIN, LEN_MIN, 32'h8000_0000, 32'h8000_0000, '1);
        send_baseline(1, -1, 1, ONE_Q30, 0, 2);
        send_baseline(-1, 1, -1, 0, -ONE_Q30, 3);
        send_baseline(40'sd3, 40'sd0, 40'sd5, ONE_Q30, 0, 32'd1 << 24);
        send_baseline(-40'sd3, 40'sd0, -40'sd5, ONE_Q30, 0, 32'd2 << 24);
        send_baseline(40'sd1 <<< 30, 40'sd1 <<< 30, 0, 32'd536870912, 32'd536870913, '1);
        send_baseline(40'sd12345678, -40'sd8765432, 40'sd1111, 32'd759250125,
                      32'd759250125, 32'd8000);
        send_baseline(LEN_MAX, 0, 0, 1, 0, 1);
        send_baseline(0, LEN_MIN, 0, 0, -1, 2);
        drain();

        // random phases over declination settings, extremes included
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(bur_pkg::REG_SIN_DEC, sd_set[ph]);
            write_reg(bur_pkg::REG_COS_DEC, cd_set[ph]);
            for (int i = 0; i < 200; i++)
                send_random();
            drain();
        end
        write_reg(bur_pkg::REG_SIN_DEC, $urandom);
        write_reg(bur_pkg::REG_COS_DEC, $urandom);
        for (int i = 0; i < 100; i++)
            send_random();
        drain();

        // closing stretch back to back with no idling
        quiet = 1'b1;
        for (int i = 0; i < 50; i++)
            send_random();
        drain();

        $display("covered %0d baselines, %0d uvw words checked, over 7 declination settings",
                 baselines, board.checked);
        $display("including extreme offsets, trig beyond unity and zero wavelength");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
